### hdl/prev_day_breakout_trade_signal_top_defines.svh
// Assertion helpers for the breakout signal block.
// Both expect clk and rst in scope; checks are off while rst is high.
`ifndef PREV_DAY_BREAKOUT_TRADE_SIGNAL_TOP_DEFINES_SVH
`define PREV_DAY_BREAKOUT_TRADE_SIGNAL_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BRK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BRK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/brk_pkg.sv
package brk_pkg;

  localparam int PRICE_BITS_DEF = 24;
  localparam int LOT_W          = 16;
  localparam int BPD_W          = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int COUNT_W        = 32;
  localparam int PROFIT_W       = 64;

  localparam logic [LOT_W-1:0] LOT_RST = 16'd1000;
  localparam logic [BPD_W-1:0] BPD_RST = 10'd375;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOT_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BARS_PER_DAY = 2'd1;

  // result event codes
  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_BUY         = 2'd1;
  localparam logic [1:0] EV_STOP_SELL   = 2'd2;
  localparam logic [1:0] EV_PROFIT_SELL = 2'd3;

  typedef struct packed {
    logic [LOT_W-1:0] lot;
    logic [BPD_W-1:0] bars_per_day;
  } cfg_t;

  // handshake between input stage and core
  typedef struct packed {
    logic stage_valid;  // input register holds a bar
    logic advance;      // bar moves into the result register this cycle
  } flow_t;

  function automatic logic signed [PROFIT_W-1:0] sat_add(
    input logic signed [PROFIT_W-1:0] a,
    input logic signed [PROFIT_W-1:0] b
  );
    logic signed [PROFIT_W-1:0] s;
    logic signed [PROFIT_W-1:0] res;
    s = a + b;
    res = s;
    if (a[PROFIT_W-1] == b[PROFIT_W-1] && s[PROFIT_W-1] != a[PROFIT_W-1]) begin
      res = a[PROFIT_W-1] ? {1'b1, {(PROFIT_W-1){1'b0}}} : {1'b0, {(PROFIT_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### hdl/brk_in_stage.sv
module brk_in_stage #(
  parameter int PRICE_BITS = brk_pkg::PRICE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic                                 advance,
  input  brk_pkg::cfg_t                        cfg,
  input  logic [PRICE_BITS-1:0]                bar_high,
  input  logic [PRICE_BITS-1:0]                bar_low,
  input  logic [PRICE_BITS-1:0]                bar_close,
  output logic                                 stage_valid,
  output logic [PRICE_BITS-1:0]                st_high,
  output logic [PRICE_BITS-1:0]                st_low,
  output logic [PRICE_BITS-1:0]                st_close,
  output logic [brk_pkg::LOT_W+PRICE_BITS-1:0] st_money
);

  localparam int MW = brk_pkg::LOT_W + PRICE_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // trade value is formed here so the state loop only sees an add
  always_ff @(posedge clk) begin
    if (load) begin
      st_high  <= bar_high;
      st_low   <= bar_low;
      st_close <= bar_close;
      st_money <= MW'(cfg.lot) * MW'(bar_close);
    end
  end

endmodule

### hdl/brk_core.sv
module brk_core #(
  parameter int PRICE_BITS = brk_pkg::PRICE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  brk_pkg::cfg_t                        cfg,
  input  brk_pkg::flow_t                       flow,
  input  logic                                 out_ready,
  input  logic [PRICE_BITS-1:0]                st_high,
  input  logic [PRICE_BITS-1:0]                st_low,
  input  logic [PRICE_BITS-1:0]                st_close,
  input  logic [brk_pkg::LOT_W+PRICE_BITS-1:0] st_money,
  output logic                                 out_valid,
  output logic [1:0]                           event_res,
  output logic                                 position_open,
  output logic                                 warming_up,
  output logic [brk_pkg::COUNT_W-1:0]          trade_count,
  output logic signed [brk_pkg::PROFIT_W-1:0]  net_profit,
  output logic [PRICE_BITS-1:0]                entry_price
);

  localparam int BW = brk_pkg::BPD_W;
  localparam int CW = brk_pkg::COUNT_W;
  localparam int PW = brk_pkg::PROFIT_W;
  localparam int MW = brk_pkg::LOT_W + PRICE_BITS;
  localparam int SW = PRICE_BITS + 4;  // signed compare width

  logic                  warmup_phase, warmup_phase_next;
  logic [BW-1:0]         bar_counter, bar_counter_next;
  logic [PRICE_BITS-1:0] base_high, base_high_next;
  logic [PRICE_BITS-1:0] base_low, base_low_next;
  logic [PRICE_BITS-1:0] day_high, day_high_next;
  logic [PRICE_BITS-1:0] day_low, day_low_next;
  logic                  holding, holding_next;
  logic [PRICE_BITS-1:0] buy_level, buy_level_next;
  logic [CW-1:0]         trades_done, trades_done_next;
  logic signed [PW-1:0]  profit_acc, profit_acc_next;
  logic [1:0]            event_next;

  logic [BW-1:0]         bpd;
  logic [BW:0]           cnt_inc;
  logic [BW-1:0]         cnt_base;
  logic [PRICE_BITS-1:0] day_high_base, day_low_base;
  logic signed [SW-1:0]  range_s, buy_s, lo_s, hi_s;
  logic signed [PW-1:0]  money;
  logic [CW-1:0]         trades_inc;

  assign bpd        = (cfg.bars_per_day == '0) ? BW'(1) : cfg.bars_per_day;
  assign money      = $signed({{(PW-MW){1'b0}}, st_money});
  assign trades_inc = (trades_done == '1) ? trades_done : trades_done + CW'(1);

  always_comb begin
    warmup_phase_next  = warmup_phase;
    bar_counter_next   = bar_counter;
    base_high_next     = base_high;
    base_low_next      = base_low;
    day_high_next      = day_high;
    day_low_next       = day_low;
    holding_next       = holding;
    buy_level_next     = buy_level;
    trades_done_next   = trades_done;
    profit_acc_next    = profit_acc;
    event_next         = brk_pkg::EV_NONE;
    cnt_inc            = {1'b0, bar_counter} + (BW+1)'(1);
    cnt_base           = bar_counter;
    day_high_base      = day_high;
    day_low_base       = day_low;
    range_s            = '0;
    buy_s              = $signed({4'b0, buy_level});
    lo_s               = $signed({4'b0, st_low});
    hi_s               = $signed({4'b0, st_high});

    if (warmup_phase) begin
      if (st_high > base_high) base_high_next = st_high;
      if (st_low < base_low) base_low_next = st_low;
      if (cnt_inc >= {1'b0, bpd}) begin
        warmup_phase_next = 1'b0;
        bar_counter_next  = '0;
        day_high_next     = '0;
        day_low_next      = '1;
      end else begin
        bar_counter_next = cnt_inc[BW-1:0];
      end
    end else begin
      // day roll: today's extremes become the baseline
      if (bar_counter >= bpd) begin
        cnt_base       = '0;
        base_high_next = day_high;
        base_low_next  = day_low;
        day_high_base  = '0;
        day_low_base   = '1;
      end
      day_high_next = (st_high > day_high_base) ? st_high : day_high_base;
      day_low_next  = (st_low < day_low_base) ? st_low : day_low_base;
      bar_counter_next = cnt_base + BW'(1);

      range_s = $signed({4'b0, base_high_next}) - $signed({4'b0, base_low_next});

      if (!holding) begin
        if (st_high > base_high_next) begin
          holding_next     = 1'b1;
          buy_level_next   = st_close;
          trades_done_next = trades_inc;
          profit_acc_next  = brk_pkg::sat_add(profit_acc, -money);
          event_next       = brk_pkg::EV_BUY;
        end
      end else if ((lo_s <<< 2) < ((buy_s <<< 2) - range_s)) begin
        holding_next     = 1'b0;
        trades_done_next = trades_inc;
        profit_acc_next  = brk_pkg::sat_add(profit_acc, money);
        event_next       = brk_pkg::EV_STOP_SELL;
      end else if (hi_s > (buy_s + range_s)) begin
        holding_next     = 1'b0;
        trades_done_next = trades_inc;
        profit_acc_next  = brk_pkg::sat_add(profit_acc, money);
        event_next       = brk_pkg::EV_PROFIT_SELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_phase  <= 1'b1;
      bar_counter   <= '0;
      base_high     <= '0;
      base_low      <= '1;
      day_high      <= '0;
      day_low       <= '1;
      holding       <= 1'b0;
      buy_level     <= '0;
      trades_done   <= '0;
      profit_acc    <= '0;
    end else if (flow.advance) begin
      warmup_phase  <= warmup_phase_next;
      bar_counter   <= bar_counter_next;
      base_high     <= base_high_next;
      base_low      <= base_low_next;
      day_high      <= day_high_next;
      day_low       <= day_low_next;
      holding       <= holding_next;
      buy_level     <= buy_level_next;
      trades_done   <= trades_done_next;
      profit_acc    <= profit_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (flow.advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flow.advance) begin
      event_res     <= event_next;
      position_open <= holding_next;
      warming_up    <= warmup_phase;
      trade_count   <= trades_done_next;
      net_profit    <= profit_acc_next;
      entry_price   <= buy_level_next;
    end
  end

endmodule

### hdl/prev_day_breakout_trade_signal_top.sv
// Previous-day high/low breakout signal, one result beat per bar beat.
// Input channel: in_valid/in_ready with bar_high, bar_low, bar_close.
// Output channel: out_valid/out_ready with event_res, position_open,
// warming_up, trade_count, net_profit and entry_price.
// Config: cfg_we writes cfg_data into register cfg_index (0 trade size,
// 1 bars per day); other indexes are ignored. Write only while idle.
// A bar accepted into the input register moves on into the result register,
// where it shows on the output until out_ready takes it.
// Throughput: one bar per cycle while the output is not stalled. The
// product of lot size and close is formed in the input register stage;
// the per-bar state loop (compares, day roll, saturating profit add)
// closes combinationally between that stage and the result register.
// Stall: while out_ready is low the result holds; one more bar can wait
// in the input stage, then in_ready drops until the result is taken.
// Reset (rst, synchronous): config returns to 1000 units and 375 bars,
// warm-up restarts, both stages empty.
`include "prev_day_breakout_trade_signal_top_defines.svh"

module prev_day_breakout_trade_signal_top #(
  parameter int PRICE_BITS = brk_pkg::PRICE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [brk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brk_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [PRICE_BITS-1:0]               bar_high,
  input  logic [PRICE_BITS-1:0]               bar_low,
  input  logic [PRICE_BITS-1:0]               bar_close,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          event_res,
  output logic                                position_open,
  output logic                                warming_up,
  output logic [brk_pkg::COUNT_W-1:0]         trade_count,
  output logic signed [brk_pkg::PROFIT_W-1:0] net_profit,
  output logic [PRICE_BITS-1:0]               entry_price
);

  localparam int MW = brk_pkg::LOT_W + PRICE_BITS;

  brk_pkg::cfg_t  cfg;
  brk_pkg::flow_t flow;
  logic           out_free;
  logic           in_load;
  logic           stage_full;
  logic           adv;

  logic [PRICE_BITS-1:0] st_high, st_low, st_close;
  logic [MW-1:0]         st_money;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lot          <= brk_pkg::LOT_RST;
      cfg.bars_per_day <= brk_pkg::BPD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brk_pkg::CFG_LOT_SIZE:     cfg.lot          <= cfg_data[brk_pkg::LOT_W-1:0];
        brk_pkg::CFG_BARS_PER_DAY: cfg.bars_per_day <= cfg_data[brk_pkg::BPD_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  assign adv      = stage_full && out_free;
  assign flow     = '{stage_valid: stage_full, advance: adv};
  assign in_ready = !stage_full || out_free;
  assign in_load  = in_valid && in_ready;

  brk_in_stage #(.PRICE_BITS(PRICE_BITS)) u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (in_load),
    .advance     (adv),
    .cfg         (cfg),
    .bar_high    (bar_high),
    .bar_low     (bar_low),
    .bar_close   (bar_close),
    .stage_valid (stage_full),
    .st_high     (st_high),
    .st_low      (st_low),
    .st_close    (st_close),
    .st_money    (st_money)
  );

  brk_core #(.PRICE_BITS(PRICE_BITS)) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .flow          (flow),
    .out_ready     (out_ready),
    .st_high       (st_high),
    .st_low        (st_low),
    .st_close      (st_close),
    .st_money      (st_money),
    .out_valid     (out_valid),
    .event_res     (event_res),
    .position_open (position_open),
    .warming_up    (warming_up),
    .trade_count   (trade_count),
    .net_profit    (net_profit),
    .entry_price   (entry_price)
  );

  // input backs up only when both stages are full and the output stalls
  `BRK_ASSERT_SAME(a_backpressure, !in_ready, out_valid && !out_ready && stage_full,
                   "in_ready low without a full stalled pipe")
  // a trade event always leaves the position matching its direction
  `BRK_ASSERT_SAME(a_event_pos, out_valid && event_res != brk_pkg::EV_NONE,
                   position_open == (event_res == brk_pkg::EV_BUY), "event and position disagree")
  // warm-up beats never trade
  `BRK_ASSERT_SAME(a_warm_quiet, out_valid && warming_up,
                   event_res == brk_pkg::EV_NONE && !position_open, "trade during warm-up")
  // a loaded stage moves to the output on the next cycle unless it stalls
  `BRK_ASSERT_NEXT(a_advance, adv, out_valid, "advanced bar did not reach the output")

endmodule
